FILE: design/s3x_pkg.sv
// Package for the Scale3x upscaler: sizes, register indexes and block types.
// No dependencies.
`timescale 1ns / 1ps
package s3x_pkg;
   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 4096;
   localparam int ColW = $clog2(MaxWidth);
   localparam int RowW = $clog2(MaxHeight);

   localparam logic [1:0] RegWidth     = 2'd0;
   localparam logic [1:0] RegHeight    = 2'd1;
   localparam logic [1:0] RegTolerance = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [11:0] out_col;
      logic [13:0] out_row;
      logic [31:0] left_rgba;
      logic [31:0] middle_rgba;
      logic [31:0] right_rgba;
      logic        last_of_run;
      logic        last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [1:0] index;
      logic [12:0] data;
   } csr_type;

   // One pending block: 3x3 neighborhood (A..I) and its position.
   typedef struct packed {
      logic [8:0][31:0] nb;
      logic [11:0]      col;
      logic [13:0]      row;
      logic             last_run;
      logic             last_frame;
   } blk_type;

   function automatic logic similar(input logic [31:0] p, input logic [31:0] q,
                                    input logic [7:0] tol);
      logic ok;
      logic [7:0] d;
      ok = 1'b1;
      for (int s = 0; s < 4; s++) begin
         d = (p[s*8 +: 8] > q[s*8 +: 8]) ? p[s*8 +: 8] - q[s*8 +: 8]
                                         : q[s*8 +: 8] - p[s*8 +: 8];
         if (d > tol) ok = 1'b0;
      end
      return ok;
   endfunction
endpackage

FILE: design/s3x_if.sv
// Valid/ready channel interfaces for the Scale3x upscaler.
// Depends on s3x_pkg.
`timescale 1ns / 1ps
interface s3x_req_if;
   logic valid;
   logic ready;
   s3x_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface s3x_rsp_if;
   logic valid;
   logic ready;
   s3x_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface s3x_csr_if;
   logic valid;
   logic ready;
   s3x_pkg::csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/s3x_emit.sv
// Block emitter: applies the Scale3x rules to a queued neighborhood and
// sends it as three row transactions. Depends on s3x_pkg and s3x_if.
`timescale 1ns / 1ps
module s3x_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                blk_valid,
   input  s3x_pkg::blk_type    blk,
   input  logic [7:0]          tol,
   output logic                blk_ready,
   s3x_rsp_if.source           rsp
);
   s3x_pkg::blk_type cur_ff, cur_in;
   logic             busy_ff, busy_in;
   logic [1:0]       sub_ff, sub_in;
   logic [8:0][31:0] px;
   logic [31:0] a, b, c, d, e, f, g, h, i;
   logic db, dh, bf, fh, ea, ec, eg, ei, nw, ne, sw, se, last_sub;

   assign {a, b, c, d, e, f, g, h, i} = cur_ff.nb;
   always_comb begin
      db = s3x_pkg::similar(d, b, tol);
      dh = s3x_pkg::similar(d, h, tol);
      bf = s3x_pkg::similar(b, f, tol);
      fh = s3x_pkg::similar(f, h, tol);
      ea = s3x_pkg::similar(e, a, tol);
      ec = s3x_pkg::similar(e, c, tol);
      eg = s3x_pkg::similar(e, g, tol);
      ei = s3x_pkg::similar(e, i, tol);
      nw = db && !dh && !bf;
      ne = bf && !db && !fh;
      sw = dh && !fh && !db;
      se = fh && !bf && !dh;
      px[0] = nw ? d : e;
      px[1] = ((nw && !ec) || (ne && !ea)) ? b : e;
      px[2] = ne ? f : e;
      px[3] = ((sw && !ea) || (nw && !eg)) ? d : e;
      px[4] = e;
      px[5] = ((ne && !ei) || (se && !ec)) ? f : e;
      px[6] = sw ? d : e;
      px[7] = ((se && !eg) || (sw && !ei)) ? h : e;
      px[8] = se ? f : e;
   end

   assign last_sub  = (sub_ff == 2'd2);
   assign blk_ready = !busy_ff || (rsp.ready && last_sub);
   assign rsp.valid = busy_ff;

   always_comb begin
      rsp.payload.out_col = cur_ff.col;
      rsp.payload.out_row = cur_ff.row + 14'(sub_ff);
      case (sub_ff)
         2'd0: begin
            rsp.payload.left_rgba = px[0];
            rsp.payload.middle_rgba = px[1];
            rsp.payload.right_rgba = px[2];
         end
         2'd1: begin
            rsp.payload.left_rgba = px[3];
            rsp.payload.middle_rgba = px[4];
            rsp.payload.right_rgba = px[5];
         end
         default: begin
            rsp.payload.left_rgba = px[6];
            rsp.payload.middle_rgba = px[7];
            rsp.payload.right_rgba = px[8];
         end
      endcase
      rsp.payload.last_of_run = cur_ff.last_run && last_sub;
      rsp.payload.last_of_frame = cur_ff.last_frame && last_sub;
   end

   always_comb begin
      cur_in = cur_ff;
      busy_in = busy_ff;
      sub_in = sub_ff;
      if (busy_ff && rsp.ready) begin
         sub_in = last_sub ? 2'd0 : sub_ff + 2'd1;
         if (last_sub) busy_in = 1'b0;
      end
      if (blk_valid && blk_ready) begin
         cur_in = blk;
         busy_in = 1'b1;
         sub_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         busy_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         sub_ff <= sub_in;
      end
   end

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 2'd3) else $error("row index out of range");
   a_idle_sub: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> sub_ff == 2'd0 || $past(busy_ff)) else $error("stale row index");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !rsp.ready |=> $stable(sub_ff)) else $error("row advanced on stall");
endmodule

FILE: design/scale3x_pixel_upscaler.sv
// Scale3x upscaler top level: line stores, window and block queue.
// Depends on s3x_pkg, s3x_if and s3x_emit.
`timescale 1ns / 1ps
// Each source pixel yields zero to four 3x3 output blocks, each sent as three
// row transactions, one per cycle while the output is ready. After a pixel is
// accepted the input holds off while its line read completes, and the next
// pixel waits until every block of the previous one has moved into the
// emitter. Two line stores in one synchronous memory (one read, one write per
// cycle) hold the two previous rows; a read-then-write of the same column is
// interlocked by the in-flight stage. The memory needs no clearing pass after
// reset.
module scale3x_pixel_upscaler (
   input logic        clock,
   input logic        reset,
   s3x_req_if.sink    req,
   s3x_rsp_if.source  rsp,
   s3x_csr_if.sink    csr
);
   localparam int CW = s3x_pkg::ColW;
   localparam int RW = s3x_pkg::RowW;

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [7:0]  tol_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [63:0] line_mem [s3x_pkg::MaxWidth];
   logic [63:0] rd_ff;

   // stage 1: pixel in flight while line read completes
   logic          s1_ff;
   logic [31:0]   s1_px_ff;
   logic [CW-1:0] s1_c_ff;
   logic [RW-1:0] s1_r_ff;
   logic          s1_lastc_ff, s1_lastr_ff;

   logic [2:0][2:0][31:0] win_ff, win_in; // [column][row]

   // pending block queue, up to four blocks
   s3x_pkg::blk_type q_ff [4];
   logic [2:0] q_cnt_ff;
   logic [1:0] q_head_ff;
   logic       blk_ready;

   logic [CW:0] wm1;
   logic [RW:0] hm1;
   logic [CW-1:0] c_cur;
   logic [RW-1:0] r_cur;
   logic accept, lastc, lastr;

   always_comb begin
      logic [11:0] w;
      logic [13:0] h;
      w = (width_ff == 11'd0) ? 12'd1 : (width_ff > 11'(s3x_pkg::MaxWidth))
          ? 12'(s3x_pkg::MaxWidth) : {1'b0, width_ff};
      h = (height_ff == 13'd0) ? 14'd1 : (height_ff > 13'(s3x_pkg::MaxHeight))
          ? 14'(s3x_pkg::MaxHeight) : {1'b0, height_ff};
      wm1 = (CW+1)'(w - 12'd1);
      hm1 = (RW+1)'(h - 14'd1);
   end

   always_comb begin
      c_cur = req.payload.frame_start ? '0 : col_ff;
      r_cur = req.payload.frame_start ? '0 : row_ff;
      if ({1'b0, c_cur} > wm1) c_cur = wm1[CW-1:0];
      if ({1'b0, r_cur} > hm1) r_cur = hm1[RW-1:0];
      lastc = ({1'b0, c_cur} == wm1);
      lastr = ({1'b0, r_cur} == hm1);
   end

   // accept only when the queue can take this pixel's four blocks later
   assign req.ready = (q_cnt_ff == 3'd0) && !s1_ff;
   assign accept = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (lastc) begin
            col_in = '0;
            row_in = lastr ? '0 : r_cur + 1'b1;
         end else begin
            col_in = c_cur + 1'b1;
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[c_cur];
      end
      if (s1_ff) begin
         line_mem[s1_c_ff] <= {rd_ff[31:0], s1_px_ff};
      end
   end

   always_comb begin
      win_in = win_ff;
      if (s1_ff) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2][0] = rd_ff[63:32];
         win_in[2][1] = rd_ff[31:0];
         win_in[2][2] = s1_px_ff;
      end
   end

   function automatic s3x_pkg::blk_type mk(input logic [2:0][2:0][31:0] wn,
      input logic [1:0] k, input logic [CW-1:0] x, input logic [1:0] t,
      input logic [1:0] m, input logic [RW-1:0] y);
      s3x_pkg::blk_type bk;
      logic [1:0] l;
      l = (x != '0) ? k - 2'd1 : k;
      bk.nb = {wn[l][t], wn[k][t], wn[2][t], wn[l][m], wn[k][m], wn[2][m],
               wn[l][2], wn[k][2], wn[2][2]};
      bk.col = 12'(x) + 12'(x) + 12'(x);
      bk.row = 14'(y) + 14'(y) + 14'(y);
      bk.last_run = 1'b0;
      bk.last_frame = 1'b0;
      return bk;
   endfunction

   s3x_pkg::blk_type nb [4];
   s3x_pkg::blk_type q_new [4];
   logic [3:0] nv;
   always_comb begin
      logic [1:0] t0, t1;
      t0 = (s1_r_ff >= RW'(2)) ? 2'd0 : 2'd1;
      t1 = (s1_r_ff >= RW'(1)) ? 2'd1 : 2'd2;
      nb[0] = mk(win_in, 2'd1, s1_c_ff - 1'b1, t0, 2'd1, s1_r_ff - 1'b1);
      nb[1] = mk(win_in, 2'd2, s1_c_ff, t0, 2'd1, s1_r_ff - 1'b1);
      nb[2] = mk(win_in, 2'd1, s1_c_ff - 1'b1, t1, 2'd2, s1_r_ff);
      nb[3] = mk(win_in, 2'd2, s1_c_ff, t1, 2'd2, s1_r_ff);
      nv[0] = (s1_r_ff != '0) && (s1_c_ff != '0);
      nv[1] = (s1_r_ff != '0) && s1_lastc_ff;
      nv[2] = s1_lastr_ff && (s1_c_ff != '0);
      nv[3] = s1_lastr_ff && s1_lastc_ff;
   end

   // pack the valid blocks to the queue front, tag the final one
   always_comb begin
      logic [2:0] n;
      logic       tail;
      n = 3'd0;
      tail = 1'b0;
      for (int j = 0; j < 4; j++) q_new[j] = nb[j];
      for (int j = 0; j < 4; j++) begin
         if (nv[j]) begin
            tail = (nv >> (j + 1)) == 4'd0;
            q_new[n[1:0]] = nb[j];
            q_new[n[1:0]].last_run = tail;
            q_new[n[1:0]].last_frame = tail && s1_lastc_ff && s1_lastr_ff;
            n = n + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_px_ff <= {req.payload.red, req.payload.green, req.payload.blue,
                   req.payload.alpha};
      s1_c_ff <= c_cur;
      s1_r_ff <= r_cur;
      s1_lastc_ff <= lastc;
      s1_lastr_ff <= lastr;
      if (s1_ff) begin
         q_ff <= q_new;
      end
      if (reset) begin
         width_ff <= 11'd1024;
         height_ff <= 13'd1024;
         tol_ff <= 8'd50;
         col_ff <= '0;
         row_ff <= '0;
         s1_ff <= 1'b0;
         q_cnt_ff <= 3'd0;
         q_head_ff <= 2'd0;
         win_ff <= '0;
      end else begin
         if (csr.valid) begin
            unique case (csr.payload.index)
               s3x_pkg::RegWidth:     width_ff <= csr.payload.data[10:0];
               s3x_pkg::RegHeight:    height_ff <= csr.payload.data;
               s3x_pkg::RegTolerance: tol_ff <= csr.payload.data[7:0];
               default: ;
            endcase
         end
         win_ff <= win_in;
         col_ff <= col_in;
         row_ff <= row_in;
         s1_ff <= accept;
         if (s1_ff) begin
            q_cnt_ff <= 3'($countones(nv));
            q_head_ff <= 2'd0;
         end else if (q_cnt_ff != 3'd0 && blk_ready) begin
            q_cnt_ff <= q_cnt_ff - 3'd1;
            q_head_ff <= q_head_ff + 2'd1;
         end
      end
   end

   s3x_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (q_cnt_ff != 3'd0),
      .blk       (q_ff[q_head_ff]),
      .tol       (tol_ff),
      .blk_ready (blk_ready),
      .rsp       (rsp)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_ff) else $error("stage not loaded");
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= 3'd4) else $error("block queue overflow");
   a_q_empty_in: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> q_cnt_ff == 3'd0) else $error("queue overwritten");
endmodule
